@@ hw/rtl/lnsa_pkg.sv @@
package lnsa_pkg;

   localparam int NODES_DEF         = 256;
   localparam int LUX_FRAC_BITS_DEF = 8;

   localparam int ACTION_W = 2;
   localparam int ADDR_W   = 8;
   localparam int LUX_W    = 24;
   localparam int PWM_W    = 8;
   localparam int REF_W    = 8;
   localparam int TIME_W   = 32;
   localparam int COUNT_W  = 16;
   localparam int ENERGY_W = 40;
   localparam int SUM_W    = 48;
   localparam int GAIN_W   = 16;

   localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(50);

   typedef enum logic [ACTION_W-1:0] {
      ACT_MEASURE   = 2'd0,
      ACT_CONSENSUS = 2'd1,
      ACT_START     = 2'd2
   } action_type;

   typedef struct packed {
      logic [COUNT_W-1:0]  sample_count;
      logic [LUX_W-1:0]    last_lux;
      logic [LUX_W-1:0]    prior_lux;
      logic [PWM_W-1:0]    last_pwm;
      logic [ENERGY_W-1:0] energy_sum;
      logic [SUM_W-1:0]    flicker_sum;
      logic [SUM_W-1:0]    error_sum;
      logic [REF_W-1:0]    ref_lux;
      logic [LUX_W-1:0]    ctrl_lux;
      logic [LUX_W-1:0]    noise;
      logic [TIME_W-1:0]   start_time;
   } entry_type;

   typedef struct packed {
      logic capture;
      logic diff;
      logic mul;
      logic commit;
   } ctl_cmd_type;

   typedef struct packed {
      logic out_blocked;
   } ctl_sts_type;

endpackage

@@ hw/rtl/lnsa_ram.sv @@
module lnsa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/lnsa_ctrl.sv @@
module lnsa_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  lnsa_pkg::ctl_sts_type sts,
   output lnsa_pkg::ctl_cmd_type cmd
);

   import lnsa_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_DIFF,
      S_MUL,
      S_WRITE
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_stall  = 1'b1;
      case (state_ff)
         S_IDLE: begin
            req_stall   = 1'b0;
            cmd.capture = req_valid;
            if (req_valid) begin
               state_in = S_DIFF;
            end
         end
         S_DIFF: begin
            cmd.diff = 1'b1;
            state_in = S_MUL;
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_WRITE;
         end
         S_WRITE: begin
            // hold until the result register is free
            if (!sts.out_blocked) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ hw/rtl/lnsa_datapath.sv @@
module lnsa_datapath #(
   parameter int NODES         = lnsa_pkg::NODES_DEF,
   parameter int LUX_FRAC_BITS = lnsa_pkg::LUX_FRAC_BITS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  lnsa_pkg::ctl_cmd_type                  cmd,
   output lnsa_pkg::ctl_sts_type                  sts,
   input  logic [lnsa_pkg::ACTION_W-1:0]          req_action,
   input  logic [lnsa_pkg::ADDR_W-1:0]            req_node_address,
   input  logic signed [lnsa_pkg::LUX_W-1:0]      req_measured_lux,
   input  logic [lnsa_pkg::PWM_W-1:0]             req_pwm,
   input  logic signed [lnsa_pkg::LUX_W-1:0]      req_ctrl_lux,
   input  logic [lnsa_pkg::REF_W-1:0]             req_ref_lux,
   input  logic [lnsa_pkg::TIME_W-1:0]            req_start_time_ms,
   input  logic signed [lnsa_pkg::LUX_W-1:0]      req_noise_lux,
   input  logic                                   csr_wr_en,
   input  logic [lnsa_pkg::GAIN_W-1:0]            csr_wr_data,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [lnsa_pkg::ADDR_W-1:0]            rsp_out_node,
   output logic [lnsa_pkg::ENERGY_W-1:0]          rsp_energy_total,
   output logic [lnsa_pkg::SUM_W-1:0]             rsp_flicker_total,
   output logic [lnsa_pkg::SUM_W-1:0]             rsp_comfort_error_total,
   output logic [lnsa_pkg::COUNT_W-1:0]           rsp_samples_seen
);

   import lnsa_pkg::*;

   localparam int IDX_W   = $clog2(NODES);
   localparam int DIFF_W  = LUX_W + 1;
   localparam int ASUM_W  = LUX_W + 1;
   localparam int PROD_W  = ASUM_W + GAIN_W;
   localparam int REFQ_W  = LUX_W + 2;
   localparam int ERR_W   = LUX_W + 1;
   localparam int ENTRY_W = $bits(entry_type);

   logic [GAIN_W-1:0]   gain_ff;
   logic [NODES-1:0]    valid_ff;

   logic [ACTION_W-1:0] act_ff;
   logic [ADDR_W-1:0]   node_ff;
   logic [IDX_W-1:0]    idx_ff;
   logic                oor_ff;
   logic                hit_ff;
   logic [LUX_W-1:0]    lux_ff;
   logic [PWM_W-1:0]    pwm_ff;
   logic [LUX_W-1:0]    ctrl_ff;
   logic [REF_W-1:0]    ref_ff;
   logic [TIME_W-1:0]   time_ff;
   logic [LUX_W-1:0]    noise_ff;

   logic [ASUM_W-1:0]   asum_ff;
   logic                flip_ff;
   logic [COUNT_W-1:0]  cnt_ff;
   logic [ERR_W-1:0]    err_ff;
   logic                err_pos_ff;
   logic [PROD_W-1:0]   prod_ff;

   logic                rsp_valid_ff;
   logic [ADDR_W-1:0]   rsp_node_ff;
   logic [ENERGY_W-1:0] rsp_energy_ff;
   logic [SUM_W-1:0]    rsp_flicker_ff;
   logic [SUM_W-1:0]    rsp_error_ff;
   logic [COUNT_W-1:0]  rsp_count_ff;

   logic [ENTRY_W-1:0]  rd_data;
   entry_type           ent;
   entry_type           ent_new;
   logic [IDX_W-1:0]    rd_idx;
   logic                req_oor;

   logic signed [DIFF_W-1:0] d1;
   logic signed [DIFF_W-1:0] d2;
   logic [LUX_W-1:0]         a1;
   logic [LUX_W-1:0]         a2;
   logic                     flip;
   logic [REFQ_W-1:0]        ref_q;
   logic signed [REFQ_W-1:0] err;
   logic [COUNT_W-1:0]       cnt_inc;

   logic [ENERGY_W:0]   energy_add;
   logic [SUM_W:0]      flicker_add;
   logic [SUM_W:0]      error_add;
   logic [ENERGY_W-1:0] energy_sat;
   logic [SUM_W-1:0]    flicker_sat;
   logic [SUM_W-1:0]    error_sat;
   logic                write_ok;
   logic                rsp_live;
   logic                wr_en;

   assign rd_idx  = req_node_address[IDX_W-1:0];
   assign req_oor = {1'b0, req_node_address} >= (ADDR_W + 1)'(NODES);

   lnsa_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (NODES)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (idx_ff),
      .wr_data (ent_new),
      .rd_en   (cmd.capture),
      .rd_addr (rd_idx),
      .rd_data (rd_data)
   );

   assign ent = entry_type'(rd_data);

   always_comb begin
      d1 = $signed({ent.prior_lux[LUX_W-1], ent.prior_lux})
         - $signed({ent.last_lux[LUX_W-1], ent.last_lux});
      d2 = $signed({ent.last_lux[LUX_W-1], ent.last_lux})
         - $signed({lux_ff[LUX_W-1], lux_ff});
      a1 = d1[DIFF_W-1] ? LUX_W'(-d1) : LUX_W'(d1);
      a2 = d2[DIFF_W-1] ? LUX_W'(-d2) : LUX_W'(d2);
      flip = (d1[DIFF_W-1] && !d2[DIFF_W-1] && (d2 != '0))
          || (!d1[DIFF_W-1] && (d1 != '0) && d2[DIFF_W-1]);
      ref_q = REFQ_W'(ent.ref_lux) << LUX_FRAC_BITS;
      err = $signed(ref_q) - $signed({{2{lux_ff[LUX_W-1]}}, lux_ff});
      cnt_inc = (ent.sample_count == '1) ? ent.sample_count : ent.sample_count + 1'b1;
   end

   always_comb begin
      energy_add  = {1'b0, ent.energy_sum} + (ENERGY_W + 1)'(ent.last_pwm);
      flicker_add = {1'b0, ent.flicker_sum} + (SUM_W + 1)'(prod_ff);
      error_add   = {1'b0, ent.error_sum} + (SUM_W + 1)'(err_ff);
      energy_sat  = energy_add[ENERGY_W] ? '1 : energy_add[ENERGY_W-1:0];
      flicker_sat = flicker_add[SUM_W] ? '1 : flicker_add[SUM_W-1:0];
      error_sat   = error_add[SUM_W] ? '1 : error_add[SUM_W-1:0];

      ent_new  = ent;
      write_ok = 1'b0;
      case (action_type'(act_ff))
         ACT_MEASURE: begin
            write_ok = 1'b1;
            if (hit_ff) begin
               ent_new.sample_count = cnt_ff;
               if (cnt_ff >= COUNT_W'(2)) begin
                  ent_new.energy_sum = energy_sat;
               end
               if ((cnt_ff > COUNT_W'(3)) && flip_ff) begin
                  ent_new.flicker_sum = flicker_sat;
               end
               if (err_pos_ff) begin
                  ent_new.error_sum = error_sat;
               end
               ent_new.prior_lux = ent.last_lux;
            end else begin
               ent_new              = '0;
               ent_new.sample_count = COUNT_W'(1);
            end
            ent_new.last_lux = lux_ff;
            ent_new.last_pwm = pwm_ff;
         end
         ACT_CONSENSUS: begin
            write_ok = 1'b1;
            if (!hit_ff) begin
               ent_new = '0;
            end
            ent_new.ref_lux  = ref_ff;
            ent_new.ctrl_lux = ctrl_ff;
         end
         ACT_START: begin
            write_ok = 1'b1;
            if (!hit_ff) begin
               ent_new            = '0;
               ent_new.start_time = time_ff;
            end
            ent_new.noise = noise_ff;
         end
         default: begin
            write_ok = 1'b0;
         end
      endcase
      write_ok = write_ok && !oor_ff;
      rsp_live = !oor_ff && (hit_ff || write_ok);
   end

   assign wr_en = cmd.commit && write_ok;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff  <= GAIN_RESET;
         valid_ff <= '0;
      end else begin
         if (csr_wr_en) begin
            gain_ff <= csr_wr_data;
         end
         if (wr_en) begin
            valid_ff[idx_ff] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         act_ff   <= req_action;
         node_ff  <= req_node_address;
         idx_ff   <= rd_idx;
         oor_ff   <= req_oor;
         hit_ff   <= valid_ff[rd_idx];
         lux_ff   <= req_measured_lux;
         pwm_ff   <= req_pwm;
         ctrl_ff  <= req_ctrl_lux;
         ref_ff   <= req_ref_lux;
         time_ff  <= req_start_time_ms;
         noise_ff <= req_noise_lux;
      end
      if (cmd.diff) begin
         asum_ff    <= ASUM_W'(a1) + ASUM_W'(a2);
         flip_ff    <= flip;
         cnt_ff     <= cnt_inc;
         err_ff     <= ERR_W'(err);
         err_pos_ff <= !err[REFQ_W-1] && (err != '0);
      end
      if (cmd.mul) begin
         prod_ff <= PROD_W'(asum_ff) * PROD_W'(gain_ff);
      end
      if (cmd.commit) begin
         rsp_node_ff    <= node_ff;
         rsp_energy_ff  <= rsp_live ? ent_new.energy_sum : '0;
         rsp_flicker_ff <= rsp_live ? ent_new.flicker_sum : '0;
         rsp_error_ff   <= rsp_live ? ent_new.error_sum : '0;
         rsp_count_ff   <= rsp_live ? ent_new.sample_count : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign sts.out_blocked = rsp_valid_ff && rsp_stall;

   assign rsp_valid               = rsp_valid_ff;
   assign rsp_out_node            = rsp_node_ff;
   assign rsp_energy_total        = rsp_energy_ff;
   assign rsp_flicker_total       = rsp_flicker_ff;
   assign rsp_comfort_error_total = rsp_error_ff;
   assign rsp_samples_seen        = rsp_count_ff;

endmodule

@@ hw/rtl/lighting_node_stats_accumulator_unit.sv @@
// Channel  Direction  Handshake             Carries
// req      in         req_valid/req_stall   one message word per node
// rsp      out        rsp_valid/rsp_stall   node statistics word, one per message
// csr      in         csr_wr_en             flicker gain, written when idle
//
// After acceptance a result is built in steps: table read on the accepting edge, then
// step differences, gain multiply, and saturating update with write-back to the table.
// A new message is taken only after the previous one has been written back.
// Reset clears the node valid bits and the state machine at once; no clearing pass.
// A stalled result holds the next message in its write-back step.
module lighting_node_stats_accumulator_unit #(
   parameter int NODES         = lnsa_pkg::NODES_DEF,
   parameter int LUX_FRAC_BITS = lnsa_pkg::LUX_FRAC_BITS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [lnsa_pkg::ACTION_W-1:0]          req_action,
   input  logic [lnsa_pkg::ADDR_W-1:0]            req_node_address,
   input  logic signed [lnsa_pkg::LUX_W-1:0]      req_measured_lux,
   input  logic [lnsa_pkg::PWM_W-1:0]             req_pwm,
   input  logic signed [lnsa_pkg::LUX_W-1:0]      req_ctrl_lux,
   input  logic [lnsa_pkg::REF_W-1:0]             req_ref_lux,
   input  logic [lnsa_pkg::TIME_W-1:0]            req_start_time_ms,
   input  logic signed [lnsa_pkg::LUX_W-1:0]      req_noise_lux,
   input  logic                                   csr_wr_en,
   input  logic [lnsa_pkg::GAIN_W-1:0]            csr_wr_data,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [lnsa_pkg::ADDR_W-1:0]            rsp_out_node,
   output logic [lnsa_pkg::ENERGY_W-1:0]          rsp_energy_total,
   output logic [lnsa_pkg::SUM_W-1:0]             rsp_flicker_total,
   output logic [lnsa_pkg::SUM_W-1:0]             rsp_comfort_error_total,
   output logic [lnsa_pkg::COUNT_W-1:0]           rsp_samples_seen
);

   import lnsa_pkg::*;

   ctl_cmd_type cmd;
   ctl_sts_type sts;

   lnsa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   lnsa_datapath #(
      .NODES         (NODES),
      .LUX_FRAC_BITS (LUX_FRAC_BITS)
   ) u_datapath (
      .clock                   (clock),
      .reset                   (reset),
      .cmd                     (cmd),
      .sts                     (sts),
      .req_action              (req_action),
      .req_node_address        (req_node_address),
      .req_measured_lux        (req_measured_lux),
      .req_pwm                 (req_pwm),
      .req_ctrl_lux            (req_ctrl_lux),
      .req_ref_lux             (req_ref_lux),
      .req_start_time_ms       (req_start_time_ms),
      .req_noise_lux           (req_noise_lux),
      .csr_wr_en               (csr_wr_en),
      .csr_wr_data             (csr_wr_data),
      .rsp_valid               (rsp_valid),
      .rsp_stall               (rsp_stall),
      .rsp_out_node            (rsp_out_node),
      .rsp_energy_total        (rsp_energy_total),
      .rsp_flicker_total       (rsp_flicker_total),
      .rsp_comfort_error_total (rsp_comfort_error_total),
      .rsp_samples_seen        (rsp_samples_seen)
   );

endmodule

@@ test/tb_top.sv @@
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import lnsa_pkg::*;

   localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
   localparam longint unsigned ENERGY_TOP = (64'd1 << ENERGY_W) - 64'd1;
   localparam longint unsigned SUM_TOP = (64'd1 << SUM_W) - 64'd1;
   localparam int BURST_WORDS = 16;

   typedef struct {
      logic [ACTION_W-1:0]    action;
      logic [ADDR_W-1:0]      node;
      logic signed [LUX_W-1:0] lux;
      logic [PWM_W-1:0]       pwm;
      logic signed [LUX_W-1:0] control;
      logic [REF_W-1:0]       ref_lux;
      logic [TIME_W-1:0]      start_ms;
      logic signed [LUX_W-1:0] noise;
   } msg_type;

   typedef struct {
      logic [ADDR_W-1:0]   node;
      logic [ENERGY_W-1:0] energy;
      logic [SUM_W-1:0]    flicker;
      logic [SUM_W-1:0]    comfort;
      logic [COUNT_W-1:0]  samples;
   } stats_type;

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_stall;
   logic [ACTION_W-1:0]      req_action;
   logic [ADDR_W-1:0]        req_node_address;
   logic signed [LUX_W-1:0]  req_measured_lux;
   logic [PWM_W-1:0]         req_pwm;
   logic signed [LUX_W-1:0]  req_ctrl_lux;
   logic [REF_W-1:0]         req_ref_lux;
   logic [TIME_W-1:0]        req_start_time_ms;
   logic signed [LUX_W-1:0]  req_noise_lux;
   logic                     csr_wr_en;
   logic [GAIN_W-1:0]        csr_wr_data;
   logic                     rsp_valid;
   logic                     rsp_stall;
   logic [ADDR_W-1:0]        rsp_out_node;
   logic [ENERGY_W-1:0]      rsp_energy_total;
   logic [SUM_W-1:0]         rsp_flicker_total;
   logic [SUM_W-1:0]         rsp_comfort_error_total;
   logic [COUNT_W-1:0]       rsp_samples_seen;

   bit                       node_live   [NODES_DEF];
   logic [COUNT_W-1:0]       count_tab   [NODES_DEF];
   logic signed [LUX_W-1:0]  last_tab    [NODES_DEF];
   logic signed [LUX_W-1:0]  prior_tab   [NODES_DEF];
   logic [PWM_W-1:0]         pwm_tab     [NODES_DEF];
   logic [ENERGY_W-1:0]      energy_tab  [NODES_DEF];
   logic [SUM_W-1:0]         flicker_tab [NODES_DEF];
   logic [SUM_W-1:0]         error_tab   [NODES_DEF];
   logic [REF_W-1:0]         ref_tab     [NODES_DEF];
   logic [GAIN_W-1:0]        gain_now = GAIN_RESET;

   stats_type                stats_expected [$];
   int                       fail_count = 0;
   bit                       idle_on = 1'b1;

   lighting_node_stats_accumulator_unit u_dut (
      .clock                   (clock),
      .reset                   (reset),
      .req_valid               (req_valid),
      .req_stall               (req_stall),
      .req_action              (req_action),
      .req_node_address        (req_node_address),
      .req_measured_lux        (req_measured_lux),
      .req_pwm                 (req_pwm),
      .req_ctrl_lux            (req_ctrl_lux),
      .req_ref_lux             (req_ref_lux),
      .req_start_time_ms       (req_start_time_ms),
      .req_noise_lux           (req_noise_lux),
      .csr_wr_en               (csr_wr_en),
      .csr_wr_data             (csr_wr_data),
      .rsp_valid               (rsp_valid),
      .rsp_stall               (rsp_stall),
      .rsp_out_node            (rsp_out_node),
      .rsp_energy_total        (rsp_energy_total),
      .rsp_flicker_total       (rsp_flicker_total),
      .rsp_comfort_error_total (rsp_comfort_error_total),
      .rsp_samples_seen        (rsp_samples_seen)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("tb: failure");
      $finish;
   end

   function automatic stats_type predict_stats(msg_type m);
      stats_type s;
      longint d1;
      longint d2;
      longint shortfall;
      longint unsigned flick_add;
      longint unsigned acc;
      int unsigned n;
      n = m.node;
      if (m.action != ACT_UNUSED) begin
         if (!node_live[n]) begin
            node_live[n] = 1'b1;
            count_tab[n] = '0;
            last_tab[n] = '0;
            prior_tab[n] = '0;
            pwm_tab[n] = '0;
            energy_tab[n] = '0;
            flicker_tab[n] = '0;
            error_tab[n] = '0;
            ref_tab[n] = '0;
            if (m.action == ACT_MEASURE) begin
               count_tab[n] = COUNT_W'(1);
               last_tab[n] = m.lux;
               pwm_tab[n] = m.pwm;
            end else if (m.action == ACT_CONSENSUS) begin
               ref_tab[n] = m.ref_lux;
            end
         end else if (m.action == ACT_MEASURE) begin
            if (count_tab[n] != '1) count_tab[n] = count_tab[n] + 1'b1;
            if (count_tab[n] >= 2) begin
               acc = 64'(energy_tab[n]) + 64'(pwm_tab[n]);
               energy_tab[n] = ENERGY_W'((acc > ENERGY_TOP) ? ENERGY_TOP : acc);
            end
            if (count_tab[n] >= 4) begin
               d1 = longint'(prior_tab[n]) - longint'(last_tab[n]);
               d2 = longint'(last_tab[n]) - longint'(m.lux);
               if ((d1 < 0 && d2 > 0) || (d1 > 0 && d2 < 0)) begin
                  flick_add = (d1 < 0) ? -d1 : d1;
                  flick_add = flick_add + ((d2 < 0) ? -d2 : d2);
                  flick_add = flick_add * 64'(gain_now);
                  acc = 64'(flicker_tab[n]) + flick_add;
                  flicker_tab[n] = SUM_W'((acc > SUM_TOP) ? SUM_TOP : acc);
               end
            end
            shortfall = (longint'(ref_tab[n]) << LUX_FRAC_BITS_DEF) - longint'(m.lux);
            if (shortfall > 0) begin
               acc = 64'(error_tab[n]) + 64'(shortfall);
               error_tab[n] = SUM_W'((acc > SUM_TOP) ? SUM_TOP : acc);
            end
            prior_tab[n] = last_tab[n];
            last_tab[n] = m.lux;
            pwm_tab[n] = m.pwm;
         end else if (m.action == ACT_CONSENSUS) begin
            ref_tab[n] = m.ref_lux;
         end
      end
      s.node = m.node;
      s.energy = node_live[n] ? energy_tab[n] : '0;
      s.flicker = node_live[n] ? flicker_tab[n] : '0;
      s.comfort = node_live[n] ? error_tab[n] : '0;
      s.samples = node_live[n] ? count_tab[n] : '0;
      return s;
   endfunction

   function automatic msg_type random_msg();
      msg_type m;
      m.action = ACT_MEASURE;
      m.node = ADDR_W'($urandom);
      m.lux = LUX_W'($urandom);
      m.pwm = PWM_W'($urandom);
      m.control = LUX_W'($urandom);
      m.ref_lux = REF_W'($urandom);
      m.start_ms = $urandom;
      m.noise = LUX_W'($urandom);
      return m;
   endfunction

   task automatic report_mismatch(input string field, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("mismatch at %0t: %s got %0h expected %0h", $realtime, field, got, want);
      fail_count++;
   endtask

   task automatic send_word(input msg_type m);
      int unsigned gap;
      gap = idle_on ? $urandom_range(16, 0) : 0;
      @(negedge clock);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_action <= m.action;
      req_node_address <= m.node;
      req_measured_lux <= m.lux;
      req_pwm <= m.pwm;
      req_ctrl_lux <= m.control;
      req_ref_lux <= m.ref_lux;
      req_start_time_ms <= m.start_ms;
      req_noise_lux <= m.noise;
      do @(posedge clock); while (req_stall);
      stats_expected.insert(stats_expected.size(), predict_stats(m));
   endtask

   task automatic wait_for_results;
      @(negedge clock);
      req_valid <= 1'b0;
      while (stats_expected.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic set_gain(input logic [GAIN_W-1:0] g);
      wait_for_results();
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= g;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      gain_now = g;
   endtask

   task automatic send_measure(input logic [ADDR_W-1:0] node,
                               input logic signed [LUX_W-1:0] lux,
                               input logic [PWM_W-1:0] pwm);
      msg_type m;
      m = random_msg();
      m.action = ACT_MEASURE;
      m.node = node;
      m.lux = lux;
      m.pwm = pwm;
      send_word(m);
   endtask

   task automatic send_consensus(input logic [ADDR_W-1:0] node,
                                 input logic [REF_W-1:0] ref_lux,
                                 input logic signed [LUX_W-1:0] control);
      msg_type m;
      m = random_msg();
      m.action = ACT_CONSENSUS;
      m.node = node;
      m.ref_lux = ref_lux;
      m.control = control;
      send_word(m);
   endtask

   task automatic send_start(input logic [ADDR_W-1:0] node,
                             input logic [TIME_W-1:0] start_ms,
                             input logic signed [LUX_W-1:0] noise);
      msg_type m;
      m = random_msg();
      m.action = ACT_START;
      m.node = node;
      m.start_ms = start_ms;
      m.noise = noise;
      send_word(m);
   endtask

   task automatic send_unused(input logic [ADDR_W-1:0] node);
      msg_type m;
      m = random_msg();
      m.action = ACT_UNUSED;
      m.node = node;
      send_word(m);
   endtask

   task automatic test_node_creation;
      send_measure(8'd0, 24'h7FFFFF, 8'hFF);
      send_consensus(8'd255, 8'hFF, 24'h800000);
      send_start(8'd7, 32'hFFFFFFFF, 24'h800000);
      send_start(8'd7, 32'h0, 24'h7FFFFF);
      send_unused(8'd7);
   endtask

   task automatic test_measurement_math;
      send_measure(8'd255, 24'h800000, 8'd0);
      send_measure(8'd255, 24'd0, 8'd128);
      send_measure(8'd255, 24'd65280, 8'd1);
      send_measure(8'd255, -24'sd100, 8'hFF);
      send_measure(8'd255, -24'sd100, 8'd7);
      send_measure(8'd255, 24'sd500, 8'd9);
      send_measure(8'd255, 24'sd200, 8'd9);
      send_consensus(8'd255, 8'd0, 24'h7FFFFF);
      send_measure(8'd255, -24'sd1, 8'd0);
      send_unused(8'd255);
      send_consensus(8'd0, 8'd10, 24'd0);
      send_measure(8'd0, 24'd0, 8'd0);
   endtask

   task automatic test_gain_extremes;
      set_gain('0);
      send_measure(8'd1, 24'sd100, 8'd3);
      send_measure(8'd1, 24'sd0, 8'd3);
      send_measure(8'd1, 24'sd100, 8'd3);
      send_measure(8'd1, 24'sd0, 8'd3);
      set_gain('1);
      send_measure(8'd2, 24'h7FFFFF, 8'd1);
      send_measure(8'd2, 24'h800000, 8'd2);
      send_measure(8'd2, 24'h7FFFFF, 8'd3);
      send_measure(8'd2, 24'h800000, 8'd4);
   endtask

   task automatic test_random_traffic;
      logic [ADDR_W-1:0] pool [12];
      msg_type m;
      int unsigned pick;
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: set_gain(GAIN_W'($urandom_range(65535, 0)));
            1: set_gain('0);
            2: set_gain('1);
            default: set_gain(GAIN_RESET);
         endcase
         idle_on = (phase != 3);
         foreach (pool[i]) pool[i] = ADDR_W'($urandom_range(255, 0));
         repeat (100) begin
            m = random_msg();
            m.node = pool[$urandom_range(11, 0)];
            pick = $urandom_range(99, 0);
            if (pick < 70) m.action = ACT_MEASURE;
            else if (pick < 82) m.action = ACT_CONSENSUS;
            else if (pick < 95) m.action = ACT_START;
            else m.action = node_live[m.node] ? ACT_UNUSED : ACT_MEASURE;
            // keep most lux values around the reference range
            if ($urandom_range(3, 0) != 0)
               m.lux = LUX_W'(int'($urandom_range(70000, 0)) - 2000);
            send_word(m);
         end
      end
      idle_on = 1'b1;
   endtask

   task automatic test_alternating_burst;
      msg_type m;
      set_gain('1);
      idle_on = 1'b0;
      for (int k = 0; k < BURST_WORDS; k++) begin
         m = random_msg();
         m.action = ACT_MEASURE;
         m.node = 8'h5A;
         m.lux = k[0] ? 24'h800000 : 24'h7FFFFF;
         send_word(m);
      end
      idle_on = 1'b1;
   endtask

   initial begin
      int unsigned hold;
      rsp_stall <= 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         hold = idle_on ? $urandom_range(16, 0) : 0;
         if (hold != 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(negedge clock);
            rsp_stall <= 1'b0;
         end
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
         @(negedge clock);
      end
   end

   always @(posedge clock) begin
      stats_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (stats_expected.size() == 0) begin
            report_mismatch("unexpected word, node", 64'(rsp_out_node), 64'd0);
         end else begin
            want = stats_expected.pop_front();
            if (rsp_out_node !== want.node)
               report_mismatch("out_node", 64'(rsp_out_node), 64'(want.node));
            if (rsp_energy_total !== want.energy)
               report_mismatch("energy_total", 64'(rsp_energy_total), 64'(want.energy));
            if (rsp_flicker_total !== want.flicker)
               report_mismatch("flicker_total", 64'(rsp_flicker_total), 64'(want.flicker));
            if (rsp_comfort_error_total !== want.comfort)
               report_mismatch("comfort_error_total", 64'(rsp_comfort_error_total),
                               64'(want.comfort));
            if (rsp_samples_seen !== want.samples)
               report_mismatch("samples_seen", 64'(rsp_samples_seen), 64'(want.samples));
         end
      end
   end

   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_action <= ACT_MEASURE;
      req_node_address <= '0;
      req_measured_lux <= '0;
      req_pwm <= '0;
      req_ctrl_lux <= '0;
      req_ref_lux <= '0;
      req_start_time_ms <= '0;
      req_noise_lux <= '0;
      csr_wr_en <= 1'b0;
      csr_wr_data <= '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_node_creation();
      test_measurement_math();
      test_gain_extremes();
      test_random_traffic();
      test_alternating_burst();
      wait_for_results();
      repeat (20) @(posedge clock);
      if (fail_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
